// ===== rtl/rbp_pkg.sv =====
package rbp_pkg;

   // Operation selector carried on req_tuser.
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_RICE  = 2'd1,
      OP_FLUSH = 2'd2,
      OP_START = 2'd3
   } op_type;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RUN   = 5'b00010,
      ST_ESC   = 5'b00100,
      ST_FLUSH = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // Three-byte sequence that forces an escape byte, oldest byte highest.
   localparam logic [23:0] ESC_PATTERN = 24'h7FFFFE;
   localparam logic [7:0]  ESC_BYTE    = 8'h00;

   // Largest Rice parameter and largest write length.
   localparam logic [6:0]  MAX_RICE_K  = 7'd15;
   localparam logic [6:0]  MAX_WRITE_N = 7'd64;

   // Bit positions inside rsp_tuser.
   localparam int USER_VALID = 0;
   localparam int USER_OVF   = 1;

endpackage

// ===== rtl/rice_bit_packer_with_escape_stuffing_core.sv =====
// LSB-first bit packer with Rice codes and escape-byte stuffing.
//
// The req channel carries one operation per beat: write 0 to 64 bits of a
// value, write a Rice code, flush the partial byte, or start a new stream.
// The rsp channel returns one beat per emitted byte, in stream order, with
// tlast on the final beat caused by that request. A request that emits no
// byte returns one empty beat (byte_valid low). Rejected Rice codes return
// an empty beat with the overflow flag set.
//
// Bits move through a 64-bit shift register one bit per cycle, except while the
// sequencer holds at a completed byte for the receiver; each inserted escape
// byte takes its own step in the sequencer. The block takes one request at a
// time; req_tready is high only while the sequencer is idle.
//
// When the receiver stalls, the sequencer holds at the next completed byte
// until the output register is free; bits that do not complete a byte keep
// moving. Reset clears the pending byte, the byte history and the output
// register; the first request can be taken in the cycle after reset drops.
module rice_bit_packer_with_escape_stuffing_core #(
   parameter int MAX_QUOTIENT = 48
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [63:0] value, [70:64] bit_count, [71] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // last
   output logic [1:0]  rsp_tuser    // [0] byte_valid, [1] overflow
);

   localparam int QW = $clog2(MAX_QUOTIENT + 1);

   // Sequencer and bit-engine registers.
   rbp_pkg::state_type state_ff, state_in;
   logic [63:0] sr_ff, sr_in;
   logic [QW-1:0] uq_ff, uq_in;
   logic        zb_ff, zb_in;
   logic [6:0]  tot_ff, tot_in;
   logic        any_ff, any_in;
   logic        ovf_ff, ovf_in;
   logic        esc_last_ff, esc_last_in;
   logic [7:0]  pbits_ff, pbits_in;
   logic [2:0]  pcnt_ff, pcnt_in;
   logic [23:0] hist_ff, hist_in;
   logic [1:0]  hcnt_ff, hcnt_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_bv_ff, rsp_bv_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_ovf_ff, rsp_ovf_in;

   // Request fields.
   logic [63:0] req_value;
   logic [6:0]  req_count;
   logic [6:0]  write_n;
   logic [63:0] rice_q;
   logic        rice_bad;

   assign req_value = req_tdata[63:0];
   assign req_count = req_tdata[70:64];
   assign write_n   = (req_count > rbp_pkg::MAX_WRITE_N) ? rbp_pkg::MAX_WRITE_N : req_count;
   assign rice_q    = req_value >> req_count[3:0];
   assign rice_bad  = (req_count > rbp_pkg::MAX_RICE_K) || (rice_q > 64'(MAX_QUOTIENT));

   // Next bit of the current code: unary ones, the terminating zero, then value bits.
   logic       cur_bit;
   logic       byte_done;
   logic [7:0] full_byte;
   logic [6:0] tot_after;
   logic       out_free;

   assign cur_bit   = (uq_ff != '0) ? 1'b1 : (zb_ff ? 1'b0 : sr_ff[0]);
   assign byte_done = (pcnt_ff == 3'd7);
   assign full_byte = pbits_ff | {cur_bit, 7'b0};
   assign tot_after = tot_ff - 7'd1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Byte history update for whatever byte is emitted this cycle.
   logic [7:0]  emit_val;
   logic [23:0] hist_new;
   logic [1:0]  hcnt_new;
   logic        esc_need;

   always_comb begin
      emit_val = full_byte;
      if (state_ff == rbp_pkg::ST_ESC) begin
         emit_val = rbp_pkg::ESC_BYTE;
      end else if (state_ff == rbp_pkg::ST_FLUSH) begin
         emit_val = pbits_ff;
      end
   end

   assign hist_new = {hist_ff[15:0], emit_val};
   assign hcnt_new = (hcnt_ff == 2'd3) ? 2'd3 : hcnt_ff + 2'd1;
   assign esc_need = (hcnt_ff >= 2'd2) && (hist_new == rbp_pkg::ESC_PATTERN);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      sr_in        = sr_ff;
      uq_in        = uq_ff;
      zb_in        = zb_ff;
      tot_in       = tot_ff;
      any_in       = any_ff;
      ovf_in       = ovf_ff;
      esc_last_in  = esc_last_ff;
      pbits_in     = pbits_ff;
      pcnt_in      = pcnt_ff;
      hist_in      = hist_ff;
      hcnt_in      = hcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (state_ff)
         rbp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               any_in = 1'b0;
               ovf_in = 1'b0;
               case (rbp_pkg::op_type'(req_tuser))
                  rbp_pkg::OP_WRITE: begin
                     sr_in    = req_value;
                     uq_in    = '0;
                     zb_in    = 1'b0;
                     tot_in   = write_n;
                     state_in = (write_n == 7'd0) ? rbp_pkg::ST_DONE : rbp_pkg::ST_RUN;
                  end
                  rbp_pkg::OP_RICE: begin
                     if (rice_bad) begin
                        ovf_in   = 1'b1;
                        state_in = rbp_pkg::ST_DONE;
                     end else begin
                        sr_in    = req_value;
                        uq_in    = rice_q[QW-1:0];
                        zb_in    = 1'b1;
                        tot_in   = 7'(rice_q[QW-1:0]) + req_count + 7'd1;
                        state_in = rbp_pkg::ST_RUN;
                     end
                  end
                  rbp_pkg::OP_FLUSH: begin
                     state_in = rbp_pkg::ST_FLUSH;
                  end
                  default: begin
                     pbits_in = '0;
                     pcnt_in  = '0;
                     hist_in  = '0;
                     hcnt_in  = '0;
                     state_in = rbp_pkg::ST_DONE;
                  end
               endcase
            end
         end

         rbp_pkg::ST_RUN: begin
            if (!byte_done || out_free) begin
               // Consume one bit from the active phase.
               if (uq_ff != '0) begin
                  uq_in = uq_ff - 1'b1;
               end else if (zb_ff) begin
                  zb_in = 1'b0;
               end else begin
                  sr_in = {1'b0, sr_ff[63:1]};
               end
               tot_in = tot_after;
               if (byte_done) begin
                  // A byte is complete; it is final if fewer than eight bits remain and no escape byte follows.
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = full_byte;
                  rsp_bv_in    = 1'b1;
                  rsp_last_in  = (tot_after < 7'd8) && !esc_need;
                  rsp_ovf_in   = 1'b0;
                  hist_in      = hist_new;
                  hcnt_in      = hcnt_new;
                  pbits_in     = '0;
                  pcnt_in      = '0;
                  any_in       = 1'b1;
                  esc_last_in  = (tot_after < 7'd8);
                  if (esc_need) begin
                     state_in = rbp_pkg::ST_ESC;
                  end else if (tot_after == 7'd0) begin
                     state_in = rbp_pkg::ST_IDLE;
                  end
               end else begin
                  pbits_in = pbits_ff | (8'(cur_bit) << pcnt_ff);
                  pcnt_in  = pcnt_ff + 3'd1;
                  if (tot_after == 7'd0) begin
                     state_in = any_ff ? rbp_pkg::ST_IDLE : rbp_pkg::ST_DONE;
                  end
               end
            end
         end

         rbp_pkg::ST_ESC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rbp_pkg::ESC_BYTE;
               rsp_bv_in    = 1'b1;
               rsp_last_in  = esc_last_ff;
               rsp_ovf_in   = 1'b0;
               hist_in      = hist_new;
               hcnt_in      = hcnt_new;
               state_in     = (tot_ff == 7'd0) ? rbp_pkg::ST_IDLE : rbp_pkg::ST_RUN;
            end
         end

         rbp_pkg::ST_FLUSH: begin
            tot_in = 7'd0;
            if (pcnt_ff == 3'd0) begin
               state_in = rbp_pkg::ST_DONE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pbits_ff;
               rsp_bv_in    = 1'b1;
               rsp_last_in  = !esc_need;
               rsp_ovf_in   = 1'b0;
               hist_in      = hist_new;
               hcnt_in      = hcnt_new;
               pbits_in     = '0;
               pcnt_in      = '0;
               any_in       = 1'b1;
               esc_last_in  = 1'b1;
               state_in     = esc_need ? rbp_pkg::ST_ESC : rbp_pkg::ST_IDLE;
            end
         end

         rbp_pkg::ST_DONE: begin
            // Empty result closes a request that emitted no byte.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_bv_in    = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_ovf_in   = ovf_ff;
               state_in     = rbp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rbp_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbp_pkg::ST_IDLE;
         uq_ff        <= '0;
         zb_ff        <= 1'b0;
         tot_ff       <= '0;
         any_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         esc_last_ff  <= 1'b0;
         pbits_ff     <= '0;
         pcnt_ff      <= '0;
         hist_ff      <= '0;
         hcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         uq_ff        <= uq_in;
         zb_ff        <= zb_in;
         tot_ff       <= tot_in;
         any_ff       <= any_in;
         ovf_ff       <= ovf_in;
         esc_last_ff  <= esc_last_in;
         pbits_ff     <= pbits_in;
         pcnt_ff      <= pcnt_in;
         hist_ff      <= hist_in;
         hcnt_ff      <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sr_ff       <= sr_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_bv_ff   <= rsp_bv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_tready = (state_ff == rbp_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_bv_ff};

   // An overflow result is always an empty, final beat.
   a_ovf_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[rbp_pkg::USER_OVF] |->
         rsp_tlast && !rsp_tuser[rbp_pkg::USER_VALID])
      else $error("overflow beat is not an empty last beat");

   // An empty beat closes its request and carries a zero byte.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[rbp_pkg::USER_VALID] |-> rsp_tlast && (rsp_tdata == 8'h00))
      else $error("empty beat without tlast or with nonzero data");

   // No request is taken while the bit engine still holds bits to push.
   a_idle_no_bits: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (tot_ff == 7'd0) && (uq_ff == '0) && !zb_ff)
      else $error("request taken while bits remain");

   // Reset leaves no result in the output register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
